>>> rtl/c6502_pkg.sv
// c6502_pkg: mnemonic and addressing-mode codes, error codes and the opcode decoder
// for the 6502-style decode/execute block. No dependencies.
package c6502_pkg;

  typedef enum logic [5:0] {
    M_BAD, M_PHP, M_CLC, M_PLP, M_SEC, M_PHA, M_CLI, M_PLA, M_SEI, M_DEY,
    M_TYA, M_TAY, M_CLV, M_INY, M_CLD, M_INX, M_SED, M_TXA, M_TXS, M_TAX,
    M_TSX, M_DEX, M_NOP, M_BRK, M_BPL, M_JSR, M_BMI, M_RTI, M_BVC, M_RTS,
    M_BVS, M_BCC, M_BCS, M_BNE, M_BEQ, M_ORA, M_AND, M_EOR, M_ADC, M_STA,
    M_LDA, M_CMP, M_SBC, M_ASL, M_ROL, M_LSR, M_ROR, M_STX, M_LDX, M_DEC,
    M_INC, M_BIT, M_JMP, M_STY, M_LDY, M_CPY, M_CPX
  } mnem_t;

  typedef enum logic [2:0] {A_NONE, A_IMM, A_ZP, A_ABS, A_REL, A_OTHER} amode_t;

  typedef enum logic [2:0] {
    E_OK = 3'd0, E_ILLEGAL = 3'd1, E_ADDR = 3'd2, E_WRITE = 3'd3, E_UNIMPL = 3'd4
  } err_t;

  localparam logic [15:0] WRITE_LIMIT = 16'h4020;
  localparam logic [7:0]  F_C = 8'h01, F_Z = 8'h02, F_I = 8'h04, F_D = 8'h08;
  localparam logic [7:0]  F_B = 8'h10, F_X = 8'h20, F_V = 8'h40, F_N = 8'h80;

  typedef struct packed {
    mnem_t  mn;
    amode_t am;
  } dec_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    logic [2:0] aaa, bbb;
    logic [1:0] cc;
    aaa = op[7:5];
    bbb = op[4:2];
    cc  = op[1:0];
    d.am = A_NONE;
    d.mn = M_BAD;
    if (op[3:0] == 4'h8) begin
      unique case (op[7:4])
        4'h0: d.mn = M_PHP; 4'h1: d.mn = M_CLC; 4'h2: d.mn = M_PLP; 4'h3: d.mn = M_SEC;
        4'h4: d.mn = M_PHA; 4'h5: d.mn = M_CLI; 4'h6: d.mn = M_PLA; 4'h7: d.mn = M_SEI;
        4'h8: d.mn = M_DEY; 4'h9: d.mn = M_TYA; 4'hA: d.mn = M_TAY; 4'hB: d.mn = M_CLV;
        4'hC: d.mn = M_INY; 4'hD: d.mn = M_CLD; 4'hE: d.mn = M_INX; 4'hF: d.mn = M_SED;
        default: d.mn = M_BAD;
      endcase
    end else if (op == 8'h8A) d.mn = M_TXA;
    else if (op == 8'h9A) d.mn = M_TXS;
    else if (op == 8'hAA) d.mn = M_TAX;
    else if (op == 8'hBA) d.mn = M_TSX;
    else if (op == 8'hCA) d.mn = M_DEX;
    else if (op == 8'hEA) d.mn = M_NOP;
    else if (op[3:0] == 4'h0 && !(op[4] == 1'b0 && op[7] == 1'b1)) begin
      unique case (op[7:4])
        4'h0: d.mn = M_BRK; 4'h1: d.mn = M_BPL; 4'h2: d.mn = M_JSR; 4'h3: d.mn = M_BMI;
        4'h4: d.mn = M_RTI; 4'h5: d.mn = M_BVC; 4'h6: d.mn = M_RTS; 4'h7: d.mn = M_BVS;
        4'h9: d.mn = M_BCC; 4'hB: d.mn = M_BCS; 4'hD: d.mn = M_BNE; 4'hF: d.mn = M_BEQ;
        default: d.mn = M_BAD;
      endcase
      if (d.mn == M_JSR) d.am = A_ABS;
      else if (d.mn != M_BRK && d.mn != M_RTI && d.mn != M_RTS) d.am = A_REL;
    end else if (cc == 2'd3) d.mn = M_BAD;
    else if (cc == 2'd1) begin
      d.am = (bbb == 3'd1) ? A_ZP : (bbb == 3'd2) ? A_IMM : (bbb == 3'd3) ? A_ABS : A_OTHER;
      unique case (aaa)
        3'd0: d.mn = M_ORA; 3'd1: d.mn = M_AND; 3'd2: d.mn = M_EOR; 3'd3: d.mn = M_ADC;
        3'd4: d.mn = M_STA; 3'd5: d.mn = M_LDA; 3'd6: d.mn = M_CMP; default: d.mn = M_SBC;
      endcase
    end else begin
      d.am = (bbb == 3'd0) ? A_IMM : (bbb == 3'd1) ? A_ZP : (bbb == 3'd3) ? A_ABS : A_OTHER;
      if (op == 8'h6C) d.am = A_OTHER;
      if (cc == 2'd2) begin
        unique case (aaa)
          3'd0: d.mn = M_ASL; 3'd1: d.mn = M_ROL; 3'd2: d.mn = M_LSR; 3'd3: d.mn = M_ROR;
          3'd4: d.mn = M_STX; 3'd5: d.mn = M_LDX; 3'd6: d.mn = M_DEC; default: d.mn = M_INC;
        endcase
      end else begin
        unique case (aaa)
          3'd0: d.mn = M_BAD; 3'd1: d.mn = M_BIT; 3'd2: d.mn = M_JMP; 3'd3: d.mn = M_JMP;
          3'd4: d.mn = M_STY; 3'd5: d.mn = M_LDY; 3'd6: d.mn = M_CPY; default: d.mn = M_CPX;
        endcase
      end
    end
    return d;
  endfunction

endpackage

>>> rtl/cpu_6502_decode_execute.sv
// cpu_6502_decode_execute: one 6502-style instruction or memory load per transaction, memory in a byte RAM.
// Depends on c6502_pkg.
//
//  channel | direction | handshake    | payload
//  in_     | input     | valid/ready  | kind, opcode, operands, next_pc, load address/data
//  out_    | output    | valid/ready  | pc_out, acc, index_x, index_y, stack_pointer, flags, error
//
// Each transaction passes two stages: S1 decodes and issues the memory read (operand or
// stack byte); S2 takes the registered read data, updates A/X/Y/SP/P, writes back and loads
// the output register. Sustained rate is one transaction per cycle while out_ does not stall.
// RTS needs two stack bytes on one read port, so it holds S1 while the first byte is read.
// A read that follows a store, push or JSR still in S2 to the same entry is forwarded from
// S2's write data; stack reads take their SP from S2's result while S2 holds an instruction.
// Register state is only updated in S2; S1 uses only SP, which it takes through S2.
// Reset clears registers and valid bits; the RAM is not cleared. A stalled out_ stalls S2,
// which keeps its read byte, and then S1, and in_ready drops.
module cpu_6502_decode_execute
  import c6502_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_operand_low,
  input  logic [7:0]  in_operand_high,
  input  logic [15:0] in_next_pc,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pc_out,
  output logic [7:0]  out_acc,
  output logic [7:0]  out_index_x,
  output logic [7:0]  out_index_y,
  output logic [7:0]  out_stack_pointer,
  output logic [7:0]  out_flags,
  output logic [2:0]  out_error
);

  localparam int AW = MEM_ADDR_BITS;

  logic [7:0] mem [0:(1<<AW)-1];

  // architectural registers (committed by the execute stage)
  logic [7:0] a_r, x_r, y_r, sp_r, p_r;

  // execute stage (S2) holding register
  logic        s2_v_r;
  logic        s2_kind_r;
  dec_t        s2_dec_r;
  logic [7:0]  s2_lo_r, s2_hi_r;
  logic [15:0] s2_pc_r, s2_ld_addr_r;
  logic [7:0]  s2_ld_data_r;
  logic [7:0]  rd0, rd1;       // first / second read byte (second only for RTS)

  // RTS sequencing in S1
  logic        rts_ph_r;       // first stack byte already read

  logic        out_v_r;
  logic        s2_go;

  // --- S1: decode and read address ---
  dec_t       d1;
  logic       s1_adv, in_fire;
  logic       is_read1, is_rts1, is_pull1;
  logic [AW-1:0] raddr;
  logic [15:0] raddr16;

  // SP value seen by S1: account for the instruction in S2 (not yet committed)
  logic [7:0] sp_eff;
  logic [7:0] sp_after_s2;

  always_comb begin
    d1 = decode(in_opcode);
    is_read1 = in_kind && (d1.mn >= M_ORA) && d1.mn != M_STA && d1.mn != M_STX
               && d1.mn != M_STY && d1.mn != M_JMP;
    is_rts1  = in_kind && d1.mn == M_RTS;
    is_pull1 = in_kind && (d1.mn == M_PLA || d1.mn == M_PLP);
  end

  // S2 write and SP result, computed below, used for forwarding
  logic          wr_en, wr2_en;
  logic [15:0]   wr_addr, wr2_addr;
  logic [7:0]    wr_data, wr2_data;
  logic [7:0]    a_n, x_n, y_n, sp_n, p_n;
  logic [15:0]   pc_n;
  err_t          err_n;

  always_comb begin
    sp_after_s2 = (s2_v_r) ? sp_n : sp_r;
    sp_eff = sp_after_s2;
    raddr16 = 16'h0;
    if (is_rts1 || is_pull1)
      raddr16 = 16'h0100 + {8'h00, sp_eff + (rts_ph_r ? 8'd2 : 8'd1)};
    else if (is_read1)
      raddr16 = (d1.am == A_ZP) ? {8'h00, in_operand_low} : {in_operand_high, in_operand_low};
    raddr = raddr16[AW-1:0];
  end

  // S1 may advance into S2 when S2 is free or moving on
  assign s2_go   = !out_v_r || out_ready;
  assign s1_adv  = in_valid && (!s2_v_r || s2_go) && !(is_rts1 && !rts_ph_r);
  assign in_ready = (!s2_v_r || s2_go) && !(in_kind && d1.mn == M_RTS && !rts_ph_r);
  assign in_fire = in_valid && in_ready;

  // forwarding: bytes written by S2 this cycle that S1 reads now
  logic [7:0] mrd, fwd_d;
  logic       fwd_hit;
  always_comb begin
    fwd_hit = 1'b0;
    fwd_d   = 8'h00;
    if (s2_v_r && wr_en && wr_addr[AW-1:0] == raddr) begin
      fwd_hit = 1'b1; fwd_d = wr_data;
    end
    if (s2_v_r && wr2_en && wr2_addr[AW-1:0] == raddr) begin
      fwd_hit = 1'b1; fwd_d = wr2_data;
    end
  end

  always_ff @(posedge clk) begin
    mrd <= mem[raddr];
    if (s2_v_r && s2_go && wr_en)  mem[wr_addr[AW-1:0]]  <= wr_data;
    if (s2_v_r && s2_go && wr2_en) mem[wr2_addr[AW-1:0]] <= wr2_data;
  end

  // forwarding register: captures S2's write when it targets the byte S1 reads
  logic       fwd_r;
  logic [7:0] fwd_d_r;
  logic [7:0] rd_now;
  always_ff @(posedge clk) begin
    fwd_r   <= fwd_hit && s2_go;
    fwd_d_r <= fwd_d;
  end
  assign rd_now = fwd_r ? fwd_d_r : mrd;

  // RTS first-byte phase: hold the instruction, park first byte
  logic [7:0] rts_lo_r;
  logic       rts_cap_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rts_ph_r <= 1'b0;
      rts_cap_r <= 1'b0;
    end else begin
      rts_cap_r <= 1'b0;
      if (in_valid && is_rts1 && !rts_ph_r && (!s2_v_r || s2_go)) begin
        rts_ph_r <= 1'b1;
        rts_cap_r <= 1'b1;
      end else if (in_fire) begin
        rts_ph_r <= 1'b0;
      end
    end
    if (rts_cap_r) rts_lo_r <= rd_now;
  end

  // S2 keeps its read byte while the result side stalls
  logic       rd_fresh_r;
  logic [7:0] rd_hold_r, rd_s2;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_fresh_r <= 1'b0;
    end else begin
      rd_fresh_r <= in_fire;
    end
    if (rd_fresh_r) rd_hold_r <= rd_now;
  end
  assign rd_s2 = rd_fresh_r ? rd_now : rd_hold_r;

  // --- S2 register ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (in_fire) begin
      s2_v_r <= 1'b1;
    end else if (s2_go) begin
      s2_v_r <= 1'b0;
    end
    if (in_fire) begin
      s2_kind_r    <= in_kind;
      s2_dec_r     <= d1;
      s2_lo_r      <= in_operand_low;
      s2_hi_r      <= in_operand_high;
      s2_pc_r      <= in_next_pc;
      s2_ld_addr_r <= in_load_address;
      s2_ld_data_r <= in_load_data;
    end
  end

  // read data for S2: rd_s2 is the byte read in S1's last cycle.
  // For RTS, rd0 is the low byte parked earlier; rd_s2 the high byte.
  logic rts_s2;
  assign rts_s2 = s2_kind_r && s2_dec_r.mn == M_RTS;
  always_comb begin
    rd0 = rts_s2 ? rts_lo_r : rd_s2;
    rd1 = rd_s2;
  end

  // --- S2: execute ---
  logic [7:0] m;
  logic [8:0] sum;
  logic [15:0] abs_a, tgt, ret;
  logic is_store, is_read, taken;
  logic [7:0] cr;

  always_comb begin
    a_n = a_r; x_n = x_r; y_n = y_r; sp_n = sp_r; p_n = p_r;
    pc_n = s2_pc_r; err_n = E_OK;
    wr_en = 1'b0; wr_addr = 16'h0; wr_data = 8'h00;
    wr2_en = 1'b0; wr2_addr = 16'h0; wr2_data = 8'h00;
    abs_a = {s2_hi_r, s2_lo_r};
    is_store = s2_dec_r.mn == M_STA || s2_dec_r.mn == M_STX || s2_dec_r.mn == M_STY;
    is_read  = s2_dec_r.mn >= M_ORA && !is_store && s2_dec_r.mn != M_JMP;
    m = (s2_dec_r.am == A_IMM) ? s2_lo_r : rd0;
    sum = 9'h0; cr = 8'h00; taken = 1'b0;
    tgt = 16'h0; ret = 16'h0;
    if (!s2_kind_r) begin
      pc_n = 16'h0;
      wr_en = 1'b1; wr_addr = s2_ld_addr_r; wr_data = s2_ld_data_r;
    end else if (s2_dec_r.mn == M_BAD) begin
      err_n = E_ILLEGAL;
    end else if (s2_dec_r.mn == M_ASL || s2_dec_r.mn == M_ROL || s2_dec_r.mn == M_LSR ||
                 s2_dec_r.mn == M_ROR || s2_dec_r.mn == M_DEC || s2_dec_r.mn == M_INC ||
                 s2_dec_r.mn == M_BRK || s2_dec_r.mn == M_RTI) begin
      err_n = E_UNIMPL;
    end else if ((is_read && s2_dec_r.am != A_IMM && s2_dec_r.am != A_ZP &&
                  s2_dec_r.am != A_ABS) ||
                 (is_store && s2_dec_r.am != A_ZP && s2_dec_r.am != A_ABS) ||
                 (s2_dec_r.mn == M_JMP && s2_dec_r.am != A_ABS)) begin
      err_n = E_ADDR;
    end else if (is_store) begin
      tgt = (s2_dec_r.am == A_ZP) ? {8'h00, s2_lo_r} : abs_a;
      if (tgt >= WRITE_LIMIT) err_n = E_WRITE;
      else begin
        wr_en = 1'b1; wr_addr = tgt;
        wr_data = (s2_dec_r.mn == M_STA) ? a_r : (s2_dec_r.mn == M_STX) ? x_r : y_r;
      end
    end else begin
      unique case (s2_dec_r.mn)
        M_LDA: begin a_n = m; cr = m; end
        M_LDX: begin x_n = m; cr = m; end
        M_LDY: begin y_n = m; cr = m; end
        M_ORA: begin a_n = a_r | m; cr = a_n; end
        M_AND: begin a_n = a_r & m; cr = a_n; end
        M_EOR: begin a_n = a_r ^ m; cr = a_n; end
        M_CMP, M_CPX, M_CPY: begin
          cr = (s2_dec_r.mn == M_CMP) ? a_r : (s2_dec_r.mn == M_CPX) ? x_r : y_r;
          sum = {1'b0, cr} - {1'b0, m};
          p_n[0] = !sum[8];
          cr = sum[7:0];
        end
        M_BIT: begin
          p_n[1] = (m & a_r) == 8'h00; p_n[7] = m[7]; p_n[6] = m[6];
        end
        M_ADC, M_SBC: begin
          cr = (s2_dec_r.mn == M_SBC) ? ~m : m;
          sum = {1'b0, a_r} + {1'b0, cr} + {8'h00, p_r[0]};
          p_n[0] = sum[8];
          p_n[6] = (a_r[7] == cr[7]) && (sum[7] != a_r[7]);
          a_n = sum[7:0];
          cr = sum[7:0];
        end
        M_INX: begin x_n = x_r + 8'd1; cr = x_n; end
        M_INY: begin y_n = y_r + 8'd1; cr = y_n; end
        M_DEX: begin x_n = x_r - 8'd1; cr = x_n; end
        M_DEY: begin y_n = y_r - 8'd1; cr = y_n; end
        M_TAX: begin x_n = a_r; cr = a_r; end
        M_TAY: begin y_n = a_r; cr = a_r; end
        M_TXA: begin a_n = x_r; cr = x_r; end
        M_TYA: begin a_n = y_r; cr = y_r; end
        M_TSX: begin x_n = sp_r; cr = sp_r; end
        M_TXS: sp_n = x_r;
        M_SEC: p_n[0] = 1'b1;
        M_CLC: p_n[0] = 1'b0;
        M_SED: p_n[3] = 1'b1;
        M_CLD: p_n[3] = 1'b0;
        M_SEI: p_n[2] = 1'b1;
        M_CLI: p_n[2] = 1'b0;
        M_CLV: p_n[6] = 1'b0;
        M_PHP, M_PHA: begin
          wr_en = 1'b1; wr_addr = 16'h0100 + {8'h00, sp_r};
          wr_data = (s2_dec_r.mn == M_PHP) ? (p_r | F_B | F_X) : a_r;
          sp_n = sp_r - 8'd1;
        end
        M_PLA: begin sp_n = sp_r + 8'd1; a_n = rd0; cr = rd0; end
        M_PLP: begin sp_n = sp_r + 8'd1; p_n = (rd0 & ~F_B) | F_X; end
        M_JMP: pc_n = abs_a;
        M_JSR: begin
          ret = s2_pc_r - 16'd1;
          wr_en = 1'b1; wr_addr = 16'h0100 + {8'h00, sp_r}; wr_data = ret[15:8];
          wr2_en = 1'b1; wr2_addr = 16'h0100 + {8'h00, sp_r - 8'd1}; wr2_data = ret[7:0];
          sp_n = sp_r - 8'd2;
          pc_n = abs_a;
        end
        M_RTS: begin
          sp_n = sp_r + 8'd2;
          pc_n = {rd1, rd0} + 16'd1;
        end
        M_BPL, M_BMI, M_BVC, M_BVS, M_BCC, M_BCS, M_BNE, M_BEQ: begin
          unique case (s2_dec_r.mn)
            M_BPL: taken = !p_r[7];
            M_BMI: taken = p_r[7];
            M_BVC: taken = !p_r[6];
            M_BVS: taken = p_r[6];
            M_BCC: taken = !p_r[0];
            M_BCS: taken = p_r[0];
            M_BNE: taken = !p_r[1];
            default: taken = p_r[1];
          endcase
          if (taken) pc_n = s2_pc_r + {{8{s2_lo_r[7]}}, s2_lo_r};
        end
        default: ;
      endcase
      if (s2_dec_r.mn == M_LDA || s2_dec_r.mn == M_LDX || s2_dec_r.mn == M_LDY ||
          s2_dec_r.mn == M_ORA || s2_dec_r.mn == M_AND || s2_dec_r.mn == M_EOR ||
          s2_dec_r.mn == M_CMP || s2_dec_r.mn == M_CPX || s2_dec_r.mn == M_CPY ||
          s2_dec_r.mn == M_ADC || s2_dec_r.mn == M_SBC || s2_dec_r.mn == M_INX ||
          s2_dec_r.mn == M_INY || s2_dec_r.mn == M_DEX || s2_dec_r.mn == M_DEY ||
          s2_dec_r.mn == M_TAX || s2_dec_r.mn == M_TAY || s2_dec_r.mn == M_TXA ||
          s2_dec_r.mn == M_TYA || s2_dec_r.mn == M_TSX || s2_dec_r.mn == M_PLA) begin
        p_n[7] = cr[7];
        p_n[1] = cr == 8'h00;
      end
    end
  end

  // commit and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00; sp_r <= 8'h00; p_r <= 8'h00;
      out_v_r <= 1'b0;
    end else begin
      if (s2_v_r && s2_go) begin
        a_r <= a_n; x_r <= x_n; y_r <= y_n; sp_r <= sp_n; p_r <= p_n;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (s2_v_r && s2_go) begin
      out_pc_out <= pc_n;
      out_acc <= a_n; out_index_x <= x_n; out_index_y <= y_n;
      out_stack_pointer <= sp_n; out_flags <= p_n; out_error <= err_n;
    end
  end

  assign out_valid = out_v_r;

endmodule

>>> rtl/cpu_6502_decode_execute_chk.sv
// cpu_6502_decode_execute_chk: port-level checks, bound to the top level.
// Depends on c6502_pkg.
module cpu_6502_decode_execute_chk
  import c6502_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pc_out,
  input logic [7:0]  out_flags,
  input logic [2:0]  out_error
);
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error <= E_UNIMPL) else $error("error code out of range");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn before acceptance");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pc_out) && $stable(out_flags)
    && $stable(out_error))
    else $error("result dropped while stalled");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");
endmodule

bind cpu_6502_decode_execute cpu_6502_decode_execute_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_pc_out(out_pc_out),
  .out_flags(out_flags), .out_error(out_error)
);
